// ===== hdl/gradient_edge_magnitude_3x3_unit_macros.svh =====
// Assertion macros for the gradient edge magnitude unit.
`ifndef GRADIENT_EDGE_MAGNITUDE_3X3_UNIT_MACROS_SVH
`define GRADIENT_EDGE_MAGNITUDE_3X3_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define GEM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gem check failed");
// Next-cycle implication outside reset.
`define GEM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gem check failed");
`endif

// ===== hdl/gem_pkg.sv =====
// Package: constants and types for the gradient edge unit.
`timescale 1ns / 1ps
package gem_pkg;
  localparam int MaxWidthDefault = 1024;
  localparam int PixelBits = 8;
  localparam logic [10:0] WidthReset = 11'd640;
  localparam logic [15:0] HeightReset = 16'd480;
  localparam logic [1:0] RegMode = 2'd0;
  localparam logic [1:0] RegWidth = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;
  localparam logic ActPixel = 1'b0;
  localparam logic ActFlush = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_CALC = 4'b0100,
    ST_OUT  = 4'b1000
  } gem_state_t;

  // controller -> datapath
  typedef struct packed {
    logic start_rd;   // issue line store reads for a pixel
    logic start_fl;   // issue line store read for a flush
    logic calc;       // shift window, write line store, compute sums
    logic root;       // one step of square root
    logic root_init;
    logic load_out;
  } gem_cmd_t;

  typedef struct packed {
    logic root_done;
  } gem_sts_t;
endpackage

// ===== hdl/gem_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`timescale 1ns / 1ps
module gem_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/gem_ctrl.sv =====
// Controller state machine for the gradient edge unit.
`timescale 1ns / 1ps
module gem_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic             in_act,
  input  logic             will_out,
  input  logic             pend_nz,
  input  logic             out_free,
  input  gem_pkg::gem_sts_t sts,
  output gem_pkg::gem_cmd_t cmd,
  output logic             busy
);
  import gem_pkg::*;
  gem_state_t state, state_next;
  logic fl, fl_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fl <= 1'b0;
    end else begin
      state <= state_next;
      fl <= fl_next;
    end
  end

  always_comb begin
    state_next = state;
    fl_next = fl;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_act == ActFlush) begin
            if (pend_nz) begin
              cmd.start_fl = 1'b1;
              fl_next = 1'b1;
              state_next = ST_READ;
            end
          end else begin
            cmd.start_rd = 1'b1;
            fl_next = 1'b0;
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (fl) begin
          state_next = ST_OUT;
        end else begin
          cmd.calc = 1'b1;
          cmd.root_init = 1'b1;
          state_next = will_out ? ST_CALC : ST_IDLE;
        end
      end
      ST_CALC: begin
        cmd.root = 1'b1;
        if (sts.root_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
  assign busy = (state != ST_IDLE);
endmodule

// ===== hdl/gem_dp.sv =====
// Datapath: counters, line stores, window, gradient sums and square root.
`timescale 1ns / 1ps
module gem_dp #(
  parameter int MaxWidth = gem_pkg::MaxWidthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  gem_pkg::gem_cmd_t cmd,
  output gem_pkg::gem_sts_t sts,
  input  logic              kernel_mode,
  input  logic [10:0]       frame_width,
  input  logic [15:0]       frame_height,
  input  logic [7:0]        pixel_in,
  output logic              will_out,
  output logic              pend_nz,
  output logic [7:0]        res_pix,
  output logic              res_border,
  output logic              res_eof
);
  import gem_pkg::*;
  localparam int AW = $clog2(MaxWidth);
  localparam int WW = $clog2(MaxWidth + 2);

  logic [WW-1:0] wid, col, col_c;
  logic [15:0] hgt, row, row_c;
  logic [WW-1:0] pend;
  logic [7:0] pix;
  logic [7:0] win [9];
  logic [7:0] top_q, mid_q;
  logic       we;
  logic [AW-1:0] raddr_a, raddr_b;
  logic [AW-1:0] cur_c;
  logic [16:0] sum_sq;
  logic [7:0] root_r;
  logic [3:0] bit_i;
  logic border_r, eof_r, fl_r;
  logic signed [11:0] gx, gy;
  logic [10:0] ax, ay;
  logic [21:0] ax2, ay2;
  logic [22:0] ss;
  logic [7:0] t;
  logic [15:0] tsq;
  logic [7:0] ctr_pix;

  // effective sizes
  always_comb begin
    if (frame_width < 11'd3) wid = WW'(3);
    else if (32'(frame_width) > MaxWidth) wid = WW'(MaxWidth);
    else wid = WW'(frame_width);
    hgt = (frame_height < 16'd3) ? 16'd3 : frame_height;
    col_c = (col > wid - 1'b1) ? wid - 1'b1 : col;
    row_c = (row > hgt - 16'd1) ? hgt - 16'd1 : row;
  end
  assign cur_c = col_c[AW-1:0];
  assign will_out = (row_c >= 16'd2) || (row_c == 16'd1 && col_c != '0);
  assign pend_nz = (pend != '0);

  // flush read address (held in pixel/flush start)
  logic [WW-1:0] fk;
  always_comb begin
    fk = (pend > wid) ? '0 : (wid + 1'b1 - pend);
    if (cmd.start_fl) begin
      raddr_a = (fk == '0) ? AW'(wid - 1'b1) : AW'(fk - 1'b1);
      raddr_b = (fk == '0) ? AW'(wid - 1'b1) : AW'(fk - 1'b1);
    end else begin
      raddr_a = cur_c;
      raddr_b = cur_c;
    end
  end
  logic fl_top, fl_cap;
  logic [7:0] fl_pix;
  always_ff @(posedge clk) if (cmd.start_fl) fl_top <= (fk == '0);

  // flush read data is only valid the cycle after the read; hold it for output
  always_ff @(posedge clk) begin
    if (rst) fl_cap <= 1'b0;
    else fl_cap <= cmd.start_fl;
    if (fl_cap) fl_pix <= fl_top ? top_q : mid_q;
  end

  // row 0 store (mid) and row 1 store (top)
  gem_ram #(.Width(8), .Depth(MaxWidth)) u_mid (
    .clk, .we(we), .waddr(cur_c), .wdata(pix), .raddr(raddr_a), .rdata(mid_q));
  gem_ram #(.Width(8), .Depth(MaxWidth)) u_top (
    .clk, .we(we), .waddr(cur_c), .wdata(mid_q), .raddr(raddr_b), .rdata(top_q));
  assign we = cmd.calc;

  always_ff @(posedge clk) if (cmd.start_rd) pix <= pixel_in;

  // window sums from the shifted window
  logic [7:0] w0, w1, w2, w3, w5, w6, w7, w8;
  assign w0 = win[1]; assign w1 = win[2]; assign w2 = top_q;
  assign w3 = win[4]; assign w5 = mid_q;
  assign w6 = win[7]; assign w7 = win[8]; assign w8 = pix;
  always_comb begin
    if (kernel_mode) begin
      gx = 12'(w2) + 12'(w5) + 12'(w8) - 12'(w0) - 12'(w3) - 12'(w6);
      gy = 12'(w0) + 12'(w1) + 12'(w2) - 12'(w6) - 12'(w7) - 12'(w8);
    end else begin
      gx = 12'(w2) + 12'({w5, 1'b0}) + 12'(w8) - 12'(w0) - 12'({w3, 1'b0}) - 12'(w6);
      gy = 12'(w0) + 12'({w1, 1'b0}) + 12'(w2) - 12'(w6) - 12'({w7, 1'b0}) - 12'(w8);
    end
    ax = gx[11] ? 11'(-gx) : 11'(gx);
    ay = gy[11] ? 11'(-gy) : 11'(gy);
  end
  logic [10:0] ax_r, ay_r;
  assign ax2 = 22'(ax_r) * 22'(ax_r);
  assign ay2 = 22'(ay_r) * 22'(ay_r);
  assign ss = 23'(ax2) + 23'(ay2);
  logic sq_ok;

  // output info and counters
  logic [WW-1:0] ocol;
  logic [15:0] orow;
  always_comb begin
    if (col_c != '0) begin
      orow = row_c - 16'd1; ocol = col_c - 1'b1;
    end else begin
      orow = row_c - 16'd2; ocol = wid - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0; row <= '0; pend <= '0;
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else begin
      if (cmd.start_rd) pend <= '0;
      if (cmd.start_fl) pend <= pend - 1'b1;
      if (cmd.calc) begin
        for (int a = 0; a < 3; a++) begin
          win[a*3] <= win[a*3+1];
          win[a*3+1] <= win[a*3+2];
        end
        win[2] <= top_q; win[5] <= mid_q; win[8] <= pix;
        if (col_c >= wid - 1'b1) begin
          col <= '0;
          if (row_c >= hgt - 16'd1) begin
            row <= '0; pend <= wid + 1'b1;
          end else row <= row_c + 16'd1;
        end else col <= col_c + 1'b1;
      end
    end
  end

  // square root one bit per cycle, with a squaring cycle first
  always_ff @(posedge clk) begin
    if (cmd.start_fl) begin
      eof_r <= (pend == WW'(1));
      fl_r <= 1'b1;
    end
    if (cmd.calc) begin
      fl_r <= 1'b0;
      eof_r <= 1'b0;
      ax_r <= ax; ay_r <= ay;
      border_r <= (orow == 16'd0) || (orow >= hgt - 16'd1) ||
                  (ocol == '0) || (ocol >= wid - 1'b1);
      ctr_pix <= win[5]; // center after shift is old win[5]
      bit_i <= 4'd9;
      root_r <= '0;
      sq_ok <= 1'b0;
    end
    if (cmd.root) begin
      if (!sq_ok) begin
        sq_ok <= 1'b1;
        sum_sq <= (ss >= 23'd65536) ? 17'h1_0000 : 17'(ss);
        bit_i <= 4'd8;
      end else if (bit_i != 4'd0) begin
        if (sum_sq[16]) root_r <= 8'hFF;
        else if (17'(tsq) <= sum_sq) root_r <= t;
        bit_i <= bit_i - 4'd1;
      end
    end
  end
  assign t = root_r | (8'd1 << (bit_i - 4'd1));
  assign tsq = 16'(t) * 16'(t);
  assign sts.root_done = sq_ok && (bit_i == 4'd0);

  always_comb begin
    if (fl_r) begin
      res_pix = fl_pix;
      res_border = 1'b1;
      res_eof = eof_r;
    end else begin
      res_pix = border_r ? ctr_pix : root_r;
      res_border = border_r;
      res_eof = 1'b0;
    end
  end
endmodule

// ===== hdl/gradient_edge_magnitude_3x3_unit.sv =====
// Top level of the 3x3 gradient edge magnitude unit.
`timescale 1ns / 1ps
// channel | direction | handshake        | payload
// in      | input     | in_valid/in_stall| action, pixel_in
// out     | output    | out_valid/out_stall | pixel_out, on_border, end_of_frame
// One item at a time. A flush goes through accept, line store read and output load;
// a pixel that makes no result goes through accept and read. A pixel with a result,
// border or interior, goes through accept, read and window shift, squaring, eight
// root steps, a done step and the output load. Reset clears counters and window;
// line stores are not cleared. A held result in the output register does not
// stop the next item from entering; the input stalls while the controller is busy.
module gradient_edge_magnitude_3x3_unit #(
  parameter int MaxWidth = gem_pkg::MaxWidthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  pixel_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  pixel_out,
  output logic        on_border,
  output logic        end_of_frame,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gem_pkg::*;
  `include "gradient_edge_magnitude_3x3_unit_macros.svh"

  logic kernel_mode;
  logic [10:0] frame_width;
  logic [15:0] frame_height;
  gem_cmd_t cmd;
  gem_sts_t sts;
  logic busy, in_fire, will_out, pend_nz, out_free;
  logic [7:0] r_pix;
  logic r_bd, r_eof;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_mode <= 1'b0; frame_width <= WidthReset; frame_height <= HeightReset;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        RegMode:   kernel_mode <= pwdata[0];
        RegWidth:  frame_width <= pwdata[10:0];
        RegHeight: frame_height <= pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[3:2])
      RegMode:   prdata = {31'd0, kernel_mode};
      RegWidth:  prdata = {21'd0, frame_width};
      RegHeight: prdata = {16'd0, frame_height};
      default:   prdata = '0;
    endcase
  end

  assign in_stall = busy;
  assign in_fire = in_valid && !busy;
  assign out_free = !out_valid || !out_stall;

  gem_ctrl u_ctrl (.clk, .rst, .in_fire, .in_act(action), .will_out, .pend_nz,
    .out_free, .sts, .cmd, .busy);
  gem_dp #(.MaxWidth(MaxWidth)) u_dp (.clk, .rst, .cmd, .sts, .kernel_mode,
    .frame_width, .frame_height, .pixel_in, .will_out, .pend_nz,
    .res_pix(r_pix), .res_border(r_bd), .res_eof(r_eof));

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (cmd.load_out) begin
      pixel_out <= r_pix; on_border <= r_bd; end_of_frame <= r_eof;
    end
  end

  `GEM_ASSERT_IMPL(a_load_free, cmd.load_out, out_free)
  `GEM_ASSERT_NEXT(a_fire_busy, in_fire && action == ActPixel, busy)
  `GEM_ASSERT_IMPL(a_eof_border, out_valid && end_of_frame, on_border)
endmodule

// ===== test/gradient_edge_magnitude_3x3_unit_tb.sv =====
// Self-checking testbench for the 3x3 gradient edge magnitude unit.
`timescale 1ns / 1ps
module gradient_edge_magnitude_3x3_unit_tb;
  import gem_pkg::*;

  localparam int MaxW = 1024;
  localparam int CycleLimit = 3000000;
  localparam int SettleCycles = 30;

  typedef struct {
    logic       act;
    logic [7:0] pix;
  } pixel_item_t;

  typedef struct {
    logic [7:0] px;
    logic       brd;
    logic       eof;
  } edge_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        action;
  logic [7:0]  pixel_in;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  pixel_out;
  logic        on_border;
  logic        end_of_frame;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  gradient_edge_magnitude_3x3_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .pixel_in(pixel_in),
    .out_valid(out_valid), .out_stall(out_stall), .pixel_out(pixel_out),
    .on_border(on_border), .end_of_frame(end_of_frame),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Pixel/flush items waiting to be offered, and magnitudes still owed by the block.
  pixel_item_t  pixel_q[$];
  edge_result_t edge_q[$];

  int cycle_cnt = 0;
  int err_cnt = 0;
  int res_cnt = 0;
  int interior_cnt = 0;
  int pix_cnt;
  int frame_cnt;
  int hold_cnt;
  logic hold_done;
  logic no_idle = 1'b0;

  // Predictor copy of the block: registers, line buffers, window, raster counters.
  logic       mode_q;
  logic [10:0] width_q;
  logic [15:0] height_q;
  logic [7:0] line_mem[2*MaxW];
  logic [7:0] win[9];
  int         col_cnt;
  int         row_cnt;
  int         drain_cnt;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_cnt, edge_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Random gaps everywhere except a stretch of back-to-back traffic.
  function automatic logic idle_now();
    if (no_idle) return 1'b0;
    return $urandom_range(0, 99) < 38;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
    err_cnt++;
  endtask

  // Integer square root of gx^2+gy^2, saturated at 255.
  function automatic logic [7:0] edge_mag();
    int k, gx, gy, s, r, t;
    k = mode_q ? 1 : 2;
    gx = (win[2] + k * win[5] + win[8]) - (win[0] + k * win[3] + win[6]);
    gy = (win[0] + k * win[1] + win[2]) - (win[6] + k * win[7] + win[8]);
    s = gx * gx + gy * gy;
    if (s >= 65536) return 8'd255;
    r = 0;
    for (int b = 7; b >= 0; b--) begin
      t = r | (1 << b);
      if (t * t <= s) r = t;
    end
    return r[7:0];
  endfunction

  // Advance the predictor by one accepted transfer; queue any result it owes.
  task automatic predict_edge(input pixel_item_t it);
    int w, h, c, r, k, orow, ocol;
    logic [7:0] top, mid;
    edge_result_t res;
    w = width_q;
    if (w < 3) w = 3;
    if (w > MaxW) w = MaxW;
    h = height_q;
    if (h < 3) h = 3;
    if (it.act == ActFlush) begin
      if (drain_cnt == 0) return;
      // too many pending after a width change: restart at the first drain position
      k = (drain_cnt > w + 1) ? 0 : (w + 1 - drain_cnt);
      res.px = (k == 0) ? line_mem[MaxW + w - 1] : line_mem[k - 1];
      drain_cnt--;
      res.brd = 1'b1;
      res.eof = (drain_cnt == 0);
      edge_q.push_back(res);
      return;
    end
    drain_cnt = 0;   // a pixel drops any undrained outputs
    c = (col_cnt > w - 1) ? w - 1 : col_cnt;
    r = (row_cnt > h - 1) ? h - 1 : row_cnt;
    top = line_mem[MaxW + c];
    mid = line_mem[c];
    line_mem[MaxW + c] = mid;
    line_mem[c] = it.pix;
    for (int a = 0; a < 3; a++) begin
      win[a*3] = win[a*3+1];
      win[a*3+1] = win[a*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = it.pix;
    if (r >= 2 || (r == 1 && c >= 1)) begin
      if (c >= 1) begin
        orow = r - 1;
        ocol = c - 1;
      end else begin
        orow = r - 2;
        ocol = w - 1;
      end
      res.brd = (orow == 0 || orow >= h - 1 || ocol == 0 || ocol >= w - 1);
      res.px = res.brd ? win[4] : edge_mag();
      res.eof = 1'b0;
      edge_q.push_back(res);
    end
    if (c >= w - 1) begin
      c = 0;
      if (r >= h - 1) begin
        r = 0;
        drain_cnt = w + 1;
      end else begin
        r++;
      end
    end else begin
      c++;
    end
    col_cnt = c;
    row_cnt = r;
  endtask

  // Input driver: payload holds while stalled; at most one update per edge.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      action <= ActPixel;
      pixel_in <= 8'd0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_edge('{act: action, pix: pixel_in});
      if (pixel_q.size() > 0 && !idle_now()) begin
        pixel_item_t nxt;
        nxt = pixel_q.pop_front();
        in_valid <= 1'b1;
        action <= nxt.act;
        pixel_in <= nxt.pix;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stall: random, plus one long hold-off so the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && out_valid && frame_cnt >= 3) begin
      hold_cnt <= 400;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_now();
    end
  end

  // Output monitor: every transfer is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      edge_result_t exp_r;
      res_cnt++;
      if (edge_q.size() == 0) begin
        report_mismatch("unexpected result, pixel_out", pixel_out, -1);
      end else begin
        exp_r = edge_q.pop_front();
        if (!exp_r.brd) interior_cnt++;
        if (pixel_out !== exp_r.px) report_mismatch("pixel_out", pixel_out, exp_r.px);
        if (on_border !== exp_r.brd) report_mismatch("on_border", on_border, exp_r.brd);
        if (end_of_frame !== exp_r.eof)
          report_mismatch("end_of_frame", end_of_frame, exp_r.eof);
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input int val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegMode:   mode_q = val[0];
      RegWidth:  width_q = val[10:0];
      RegHeight: height_q = val[15:0];
      default: ;
    endcase
  endtask

  // Block is idle: nothing queued, nothing in flight, nothing owed.
  task automatic wait_idle();
    while (pixel_q.size() > 0 || in_valid || edge_q.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic queue_pixel(input logic [7:0] v);
    pixel_q.push_back('{act: ActPixel, pix: v});
    pix_cnt++;
  endtask

  task automatic queue_flush(input int n);
    repeat (n) pixel_q.push_back('{act: ActFlush, pix: 8'($urandom_range(0, 255))});
  endtask

  // Random frame content; some frames are flat regions with steps to exercise edges.
  task automatic queue_frame(input int w, input int h);
    int style;
    style = $urandom_range(0, 3);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        if ($urandom_range(0, 99) < 4) queue_flush(1);   // stray flush mid-frame
        case (style)
          0: queue_pixel(((x + y) & 1) ? 8'd255 : 8'd0);
          1: queue_pixel((x > w / 2) ? 8'd250 : 8'd5);
          default: queue_pixel(8'($urandom_range(0, 255)));
        endcase
      end
    frame_cnt++;
  endtask

  initial begin
    int w, h, pick;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = 4'd0; pwdata = 32'd0;
    pix_cnt = 0; frame_cnt = 0;
    mode_q = 1'b0; width_q = WidthReset; height_q = HeightReset;
    for (int i = 0; i < 2*MaxW; i++) line_mem[i] = 8'd0;
    for (int i = 0; i < 9; i++) win[i] = 8'd0;
    col_cnt = 0; row_cnt = 0; drain_cnt = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Sizes below the minimum act as 3x3; flush with nothing pending gives nothing.
    reg_write(RegMode, 0);
    reg_write(RegWidth, 2);
    reg_write(RegHeight, 0);
    queue_flush(1);
    for (int i = 0; i < 9; i++) queue_pixel((i & 1) ? 8'd0 : 8'd255);
    queue_flush(5);
    wait_idle();

    // Prewitt on a very tall frame, then shrink the height mid-frame so the row
    // count lies past the last row; shrink width while outputs are pending.
    reg_write(RegMode, 1);
    reg_write(RegWidth, 4);
    reg_write(RegHeight, 65535);
    for (int i = 0; i < 20; i++) queue_pixel(8'($urandom_range(0, 255)));
    wait_idle();
    reg_write(RegHeight, 3);
    for (int i = 0; i < 4; i++) queue_pixel(8'($urandom_range(0, 255)));
    wait_idle();
    reg_write(RegWidth, 3);
    queue_flush(5);
    wait_idle();

    // Partial drain, then a new pixel drops what is left.
    queue_frame(3, 3);
    queue_flush(2);
    queue_frame(3, 3);
    queue_flush(4);
    wait_idle();

    // Width above the maximum acts as full line buffer width: the row wraps
    // after MaxW pixels and the second row starts producing results.
    reg_write(RegMode, 0);
    reg_write(RegWidth, 2047);
    for (int i = 0; i < MaxW + 2; i++) queue_pixel(8'($urandom_range(0, 255)));
    wait_idle();

    // Random frames of small sizes, mostly fully drained; the first few back to back.
    while (pix_cnt < 1450) begin
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      no_idle = (frame_cnt < 5);
      reg_write(RegMode, $urandom_range(0, 1));
      reg_write(RegWidth, w);
      reg_write(RegHeight, h);
      queue_frame(w, h);
      pick = $urandom_range(0, 9);
      if (pick == 0) queue_flush($urandom_range(0, w));
      else if (pick == 1) queue_flush(w + 3);
      else queue_flush(w + 1);
      wait_idle();
    end
    no_idle = 1'b0;

    $display("covered %0d frames, %0d pixels, %0d results (%0d interior magnitudes)",
             frame_cnt, pix_cnt, res_cnt, interior_cnt);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
